// ===== rtl/core/heston_euler_path_step_assert.svh =====
// assertion macros for the heston path stepper
`ifndef HESTON_EULER_PATH_STEP_ASSERT_SVH
`define HESTON_EULER_PATH_STEP_ASSERT_SVH

// implication checked on every clock edge outside reset
`define HES_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication checked outside reset
`define HES_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== rtl/core/hes_pkg.sv =====
package hes_pkg;

    // configuration register indexes
    localparam logic [2:0] REG_INIT_STOCK = 3'd0;
    localparam logic [2:0] REG_INIT_VAR   = 3'd1;
    localparam logic [2:0] REG_DRIFT      = 3'd2;
    localparam logic [2:0] REG_KAPPA      = 3'd3;
    localparam logic [2:0] REG_THETA      = 3'd4;
    localparam logic [2:0] REG_SIGMA      = 3'd5;
    localparam logic [2:0] REG_RHO        = 3'd6;
    localparam logic [2:0] REG_DT         = 3'd7;

    localparam int unsigned SQRT_STEPS = 24;

    // multiply operand selection
    typedef enum logic [3:0] {
        MUL_VDT, MUL_RHORHO, MUL_RHOZ1, MUL_RESTZ2, MUL_KAPTH, MUL_PULLDT,
        MUL_SIGR, MUL_KICK, MUL_MUDT, MUL_SGROW, MUL_SR, MUL_SRZ1
    } t_mul_sel;

    // controller to datapath commands
    typedef struct packed {
        logic     load;
        logic     mul_en;
        t_mul_sel mul_sel;
        logic     sqrt_start;
        logic     sqrt_sel;
        logic     sqrt_done_root;
        logic     store_write;
    } t_cmd;

    // datapath to controller status
    typedef struct packed {
        logic sqrt_busy;
    } t_status;

    // q16.16 product, floor shift then saturate
    function automatic logic signed [31:0] qmul(input logic signed [31:0] a,
                                               input logic signed [31:0] b);
        logic signed [63:0] p;
        logic signed [47:0] q;
        p = 64'(a) * 64'(b);
        q = p[63:16];
        if (q > 48'sd2147483647)       qmul = 32'sh7FFFFFFF;
        else if (q < -48'sd2147483648) qmul = 32'sh80000000;
        else                           qmul = q[31:0];
    endfunction

    // saturating add
    function automatic logic signed [31:0] sadd(input logic signed [31:0] a,
                                               input logic signed [31:0] b);
        logic signed [32:0] s;
        s = 33'(a) + 33'(b);
        if (s > 33'sd2147483647)       sadd = 32'sh7FFFFFFF;
        else if (s < -33'sd2147483648) sadd = 32'sh80000000;
        else                           sadd = s[31:0];
    endfunction

    // saturating subtract
    function automatic logic signed [31:0] ssub(input logic signed [31:0] a,
                                               input logic signed [31:0] b);
        logic signed [32:0] s;
        s = 33'(a) - 33'(b);
        if (s > 33'sd2147483647)       ssub = 32'sh7FFFFFFF;
        else if (s < -33'sd2147483648) ssub = 32'sh80000000;
        else                           ssub = s[31:0];
    endfunction

endpackage

// ===== rtl/core/hes_sqrt.sv =====
// bit-serial integer square root, two radicand bits per cycle
module hes_sqrt (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [46:0] i_radicand,
    output logic        o_busy,
    output logic [23:0] o_root
);
    logic [47:0] r_rem;
    logic [47:0] r_src;
    logic [23:0] r_root;
    logic [4:0]  r_cnt;
    logic        r_busy;
    logic [49:0] w_trial;
    logic [49:0] w_rem2;

    assign w_rem2  = {r_rem, r_src[47:46]};
    assign w_trial = 50'({r_root, 2'b01});

    // one root bit per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= 5'(hes_pkg::SQRT_STEPS);
            r_rem  <= '0;
            r_root <= '0;
            r_src  <= {1'b0, i_radicand};
        end else if (r_busy) begin
            r_src <= {r_src[45:0], 2'b00};
            if (w_rem2 >= w_trial) begin
                r_rem  <= 48'(w_rem2 - w_trial);
                r_root <= {r_root[22:0], 1'b1};
            end else begin
                r_rem  <= w_rem2[47:0];
                r_root <= {r_root[22:0], 1'b0};
            end
            r_cnt <= r_cnt - 5'd1;
            if (r_cnt == 5'd1) r_busy <= 1'b0;
        end
    end

    assign o_busy = r_busy;
    assign o_root = r_root;
endmodule

// ===== rtl/core/hes_datapath.sv =====
// datapath: path stores, shared multiplier, square root unit
module hes_datapath #(
    parameter int PATHS = 1024
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  hes_pkg::t_cmd      i_cmd,
    output hes_pkg::t_status   o_status,
    input  logic [9:0]         i_path,
    input  logic               i_first,
    input  logic signed [15:0] i_z1,
    input  logic signed [15:0] i_z2,
    input  logic [30:0]        i_init_s,
    input  logic [30:0]        i_init_v,
    input  logic signed [31:0] i_mu,
    input  logic [30:0]        i_kappa,
    input  logic [30:0]        i_theta,
    input  logic [30:0]        i_sigma,
    input  logic signed [17:0] i_rho,
    input  logic [16:0]        i_dt,
    output logic [9:0]         o_path,
    output logic signed [31:0] o_stock,
    output logic signed [31:0] o_var
);
    localparam int AW = (PATHS > 1) ? $clog2(PATHS) : 1;
    // reciprocal of the depth, exact quotient for any 10-bit path
    localparam logic [26:0] RECIP =
        27'(((64'd1 << 26) + 64'(PATHS) - 64'd1) / 64'(PATHS));

    logic signed [31:0] r_mem_s [PATHS];
    logic signed [31:0] r_mem_v [PATHS];
    logic signed [31:0] r_rd_s, r_rd_v;
    logic [AW-1:0] r_addr;
    logic [9:0]    r_path;
    logic          r_first;
    logic signed [31:0] r_z1, r_z2;
    logic signed [31:0] r_s, r_v, r_prod;
    logic signed [31:0] r_root, r_rroot, r_mix, r_pull, r_kick, r_grow, r_sr, r_rhoz1;
    logic signed [31:0] w_a, w_b, w_p, w_s, w_v, w_snew, w_vnew;
    logic [AW-1:0] w_addr;
    logic [30:0]   w_rad;
    logic [23:0]   w_root;
    logic          w_busy;

    // store address is path modulo depth, by reciprocal multiply
    always_comb begin
        logic [36:0] scaled;
        logic [9:0]  quo;
        logic [26:0] back;
        scaled = 37'(i_path) * 37'(RECIP);
        quo    = scaled[35:26];
        back   = 27'(quo) * 27'(PATHS);
        w_addr = AW'(27'(i_path) - back);
    end

    // memories with registered read
    always_ff @(posedge i_clk) begin
        r_rd_s <= r_mem_s[r_addr];
        r_rd_v <= r_mem_v[r_addr];
        if (i_cmd.store_write) begin
            r_mem_s[r_addr] <= w_snew;
            r_mem_v[r_addr] <= w_vnew;
        end
    end

    assign w_s = r_first ? 32'(i_init_s) : r_rd_s;
    assign w_v = r_first ? 32'(i_init_v) : r_rd_v;

    // multiplier operand mux
    always_comb begin
        unique case (i_cmd.mul_sel)
            hes_pkg::MUL_VDT:    begin w_a = w_v[31] ? '0 : w_v; w_b = 32'(i_dt); end
            hes_pkg::MUL_RHORHO: begin w_a = 32'(i_rho); w_b = 32'(i_rho); end
            hes_pkg::MUL_RHOZ1:  begin w_a = 32'(i_rho); w_b = r_z1; end
            hes_pkg::MUL_RESTZ2: begin w_a = r_rroot; w_b = r_z2; end
            hes_pkg::MUL_KAPTH:
                begin w_a = 32'(i_kappa); w_b = hes_pkg::ssub(32'(i_theta), r_v); end
            hes_pkg::MUL_PULLDT: begin w_a = r_prod; w_b = 32'(i_dt); end
            hes_pkg::MUL_SIGR:   begin w_a = 32'(i_sigma); w_b = r_root; end
            hes_pkg::MUL_KICK:   begin w_a = r_prod; w_b = r_mix; end
            hes_pkg::MUL_MUDT:   begin w_a = i_mu; w_b = 32'(i_dt); end
            hes_pkg::MUL_SGROW:  begin w_a = r_s; w_b = r_grow; end
            hes_pkg::MUL_SR:     begin w_a = r_s; w_b = r_root; end
            hes_pkg::MUL_SRZ1:   begin w_a = r_prod; w_b = r_z1; end
            default:             begin w_a = '0; w_b = '0; end
        endcase
    end
    assign w_p = hes_pkg::qmul(w_a, w_b);

    // root operand: product clamped, or 1 - rho^2 clamped
    always_comb begin
        logic signed [32:0] rest;
        rest = 33'sd65536 - 33'(r_prod);
        if (i_cmd.sqrt_sel)
            w_rad = rest[32] ? '0 : 31'(rest);
        else
            w_rad = r_prod[31] ? '0 : r_prod[30:0];
    end

    hes_sqrt u_sqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.sqrt_start),
        .i_radicand ({w_rad, 16'd0}),
        .o_busy     (w_busy),
        .o_root     (w_root)
    );
    assign o_status.sqrt_busy = w_busy;

    assign w_vnew = hes_pkg::sadd(r_pull, r_kick);
    assign w_snew = hes_pkg::sadd(r_grow, r_sr);

    // working registers, sequenced by the controller
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_addr  <= w_addr;
            r_path  <= i_path;
            r_first <= i_first;
            r_z1    <= 32'(i_z1) <<< 4;
            r_z2    <= 32'(i_z2) <<< 4;
        end
        // variance root and correlation root kept apart
        if (i_cmd.sqrt_done_root) begin
            if (i_cmd.sqrt_sel) r_rroot <= 32'(w_root);
            else                r_root  <= 32'(w_root);
        end
        if (i_cmd.mul_en) begin
            r_prod <= w_p;
            unique case (i_cmd.mul_sel)
                hes_pkg::MUL_VDT:    begin r_s <= w_s; r_v <= w_v; end
                hes_pkg::MUL_RHOZ1:  r_rhoz1 <= w_p;
                hes_pkg::MUL_RESTZ2: r_mix <= hes_pkg::sadd(r_rhoz1, w_p);
                hes_pkg::MUL_PULLDT: r_pull <= hes_pkg::sadd(r_v, w_p);
                hes_pkg::MUL_KICK:   r_kick <= w_p;
                hes_pkg::MUL_MUDT:   r_grow <= hes_pkg::sadd(32'sd65536, w_p);
                hes_pkg::MUL_SGROW:  r_grow <= w_p;
                hes_pkg::MUL_SRZ1:   r_sr <= w_p;
                default: ;
            endcase
        end
    end

    assign o_path  = r_path;
    assign o_stock = w_snew;
    assign o_var   = w_vnew;
endmodule

// ===== rtl/core/hes_ctrl.sv =====
// sequencer for one path step
module hes_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    input  hes_pkg::t_status i_status,
    output hes_pkg::t_cmd    o_cmd
);
    typedef enum logic [6:0] {
        ST_IDLE = 7'b0000001, ST_READ = 7'b0000010, ST_MUL = 7'b0000100,
        ST_SQ   = 7'b0001000, ST_SQW  = 7'b0010000, ST_WB  = 7'b0100000,
        ST_OUT  = 7'b1000000
    } t_state;

    t_state r_state, n_state;
    logic [3:0] r_step, n_step;
    logic r_sqn, n_sqn;

    // multiply schedule; a root follows step 0 and step 1
    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        n_sqn   = r_sqn;
        o_cmd   = '0;
        o_cmd.mul_sel = hes_pkg::t_mul_sel'(r_step);
        o_cmd.sqrt_sel = r_sqn;
        unique case (r_state)
            ST_IDLE: if (i_in_valid) begin
                o_cmd.load = 1'b1;
                n_state = ST_READ;
            end
            ST_READ: begin
                n_step = '0;
                n_state = ST_MUL;
            end
            ST_MUL: begin
                o_cmd.mul_en = 1'b1;
                if (r_step == 4'd0 || r_step == 4'd1) begin
                    n_sqn = r_step[0];
                    n_state = ST_SQ;
                end else if (r_step == 4'd11) begin
                    n_state = ST_WB;
                end else begin
                    n_step = r_step + 4'd1;
                end
            end
            ST_SQ: begin
                o_cmd.sqrt_start = 1'b1;
                n_state = ST_SQW;
            end
            ST_SQW: if (!i_status.sqrt_busy) begin
                o_cmd.sqrt_done_root = 1'b1;
                n_step = r_sqn ? 4'd2 : 4'd1;
                n_state = ST_MUL;
            end
            ST_WB: begin
                o_cmd.store_write = 1'b1;
                n_state = ST_OUT;
            end
            ST_OUT: if (i_out_ready) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_step  <= '0;
            r_sqn   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
            r_sqn   <= n_sqn;
        end
    end

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = (r_state == ST_OUT);
endmodule

// ===== rtl/core/heston_euler_path_step.sv =====
// heston euler step: one item at a time, with the result valid after the store write-back
// two square roots (start, 24 bit steps, done) and twelve multiply steps
// a new item is accepted only once the result has been taken and the sequencer is idle
// reset (synchronous, active low) returns the sequencer to idle and loads defaults
// the path stores are not cleared; entries are undefined until first written
`include "heston_euler_path_step_assert.svh"
module heston_euler_path_step #(
    parameter int PATHS = 1024
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,  // path_index, shock_one, shock_two, zero pad
    input  logic        s_axis_tuser,  // first_step
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [79:0] m_axis_tdata,  // path_out, stock_value, variance_value, zero pad
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);
    logic [30:0] r_init_s, r_init_v, r_kappa, r_theta, r_sigma;
    logic signed [31:0] r_mu;
    logic signed [17:0] r_rho;
    logic [16:0] r_dt;
    hes_pkg::t_cmd    w_cmd;
    hes_pkg::t_status w_status;
    logic [9:0] w_path;
    logic signed [31:0] w_stock, w_var;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_init_s <= 31'd6553600;
            r_init_v <= 31'd2621;
            r_mu     <= '0;
            r_kappa  <= 31'd65536;
            r_theta  <= 31'd2621;
            r_sigma  <= 31'd19661;
            r_rho    <= '0;
            r_dt     <= 17'd655;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                hes_pkg::REG_INIT_STOCK: r_init_s <= i_cfg_data[30:0];
                hes_pkg::REG_INIT_VAR:   r_init_v <= i_cfg_data[30:0];
                hes_pkg::REG_DRIFT:      r_mu     <= i_cfg_data;
                hes_pkg::REG_KAPPA:      r_kappa  <= i_cfg_data[30:0];
                hes_pkg::REG_THETA:      r_theta  <= i_cfg_data[30:0];
                hes_pkg::REG_SIGMA:      r_sigma  <= i_cfg_data[30:0];
                hes_pkg::REG_RHO:        r_rho    <= i_cfg_data[17:0];
                hes_pkg::REG_DT:         r_dt     <= i_cfg_data[16:0];
                default: ;
            endcase
        end
    end

    hes_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .i_status    (w_status),
        .o_cmd       (w_cmd)
    );

    hes_datapath #(.PATHS(PATHS)) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (w_cmd),
        .o_status (w_status),
        .i_path   (s_axis_tdata[9:0]),
        .i_first  (s_axis_tuser),
        .i_z1     (s_axis_tdata[25:10]),
        .i_z2     (s_axis_tdata[41:26]),
        .i_init_s (r_init_s),
        .i_init_v (r_init_v),
        .i_mu     (r_mu),
        .i_kappa  (r_kappa),
        .i_theta  (r_theta),
        .i_sigma  (r_sigma),
        .i_rho    (r_rho),
        .i_dt     (r_dt),
        .o_path   (w_path),
        .o_stock  (w_stock),
        .o_var    (w_var)
    );

    assign m_axis_tdata = {6'd0, w_var, w_stock, w_path};

    // assertions
    `HES_ASSERT_IMP(a_excl, i_clk, i_rst_n, 1'b1, !(s_axis_tready && m_axis_tvalid))
    `HES_ASSERT_NEXT(a_busy, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready)
    `HES_ASSERT_IMP(a_wr, i_clk, i_rst_n, w_cmd.store_write, !w_cmd.load)
endmodule
